/* rtl/qrmc_pkg.sv */
// Shared types, constants and byte-class functions for the QR mode classifier.
`default_nettype none

package qrmc_pkg;

  // Result codes
  localparam logic [1:0] MODE_NUMERIC = 2'd0;
  localparam logic [1:0] MODE_ALNUM   = 2'd1;
  localparam logic [1:0] MODE_BYTE    = 2'd2;
  localparam logic [1:0] MODE_KANJI   = 2'd3;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_EMPTY   = 2'd1;
  localparam logic [1:0] STATUS_NO_MODE = 2'd2;

  // UTF-8 lead and continuation patterns
  localparam logic [2:0] UTF8_LEAD2 = 3'b110;
  localparam logic [3:0] UTF8_LEAD3 = 4'b1110;
  localparam logic [4:0] UTF8_LEAD4 = 5'b11110;
  localparam logic [1:0] UTF8_CONT  = 2'b10;

  // Shift-JIS byte ranges
  localparam logic [7:0] SJIS_LEAD_LO   = 8'h81;
  localparam logic [7:0] SJIS_LEAD_HI   = 8'h9F;
  localparam logic [7:0] SJIS_SINGLE_HI = 8'hA0;
  localparam logic [7:0] SJIS_TRAIL_LO  = 8'h40;
  localparam logic [7:0] SJIS_TRAIL_HI  = 8'hFC;
  localparam logic [7:0] SJIS_TRAIL_GAP = 8'h7F;
  localparam logic [7:0] SJIS_HIGH_BIT  = 8'h80;

  // Queue between the classifier and the result stage
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // Per-message verdict of the four checks
  typedef struct packed {
    logic empty_msg;
    logic numeric_ok;
    logic alnum_ok;
    logic utf8_ok;
    logic kanji_ok;
  } summary_t;

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    logic upper;
    logic space;
    logic symbol;
    upper  = (c >= 8'h41) && (c <= 8'h5A);
    // C whitespace (tab through carriage return) and space
    space  = ((c >= 8'h09) && (c <= 8'h0D)) || (c == 8'h20);
    symbol = (c == 8'h24) || (c == 8'h25) || (c == 8'h2A) || (c == 8'h2B) ||
             (c == 8'h2D) || (c == 8'h2E) || (c == 8'h2F) || (c == 8'h3A);
    is_alnum = is_digit(c) || upper || space || symbol;
  endfunction

endpackage

`default_nettype wire

/* rtl/qrmc_front.sv */
// Classifier front end: per-byte check updates and per-message verdicts.
`default_nettype none

module qrmc_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic [7:0]        data_byte_i,
  input  wire logic              last_i,
  input  wire logic              empty_message_i,
  output qrmc_pkg::summary_t     summary_o,
  output logic                   summary_valid_o
);
  import qrmc_pkg::*;

  logic       numeric_ok_q, numeric_ok_d;
  logic       alnum_ok_q, alnum_ok_d;
  logic [1:0] utf8_pending_q, utf8_pending_d;
  logic       utf8_bad_q, utf8_bad_d;
  logic       kanji_trail_q, kanji_trail_d;
  logic       kanji_bad_q, kanji_bad_d;

  logic [7:0] c;
  assign c = data_byte_i;

  // Digit and alphanumeric checks
  assign numeric_ok_d = numeric_ok_q & is_digit(c);
  assign alnum_ok_d   = alnum_ok_q & is_alnum(c);

  // UTF-8 structure check
  always_comb begin
    utf8_pending_d = utf8_pending_q;
    utf8_bad_d     = utf8_bad_q;
    if (!utf8_bad_q) begin
      if (utf8_pending_q == 2'd0) begin
        if (!c[7]) begin
          utf8_pending_d = 2'd0;
        end else if (c[7:5] == UTF8_LEAD2) begin
          utf8_pending_d = 2'd1;
        end else if (c[7:4] == UTF8_LEAD3) begin
          utf8_pending_d = 2'd2;
        end else if (c[7:3] == UTF8_LEAD4) begin
          utf8_pending_d = 2'd3;
        end else begin
          utf8_bad_d = 1'b1;
        end
      end else if (c[7:6] != UTF8_CONT) begin
        utf8_bad_d = 1'b1;
      end else begin
        utf8_pending_d = utf8_pending_q - 2'd1;
      end
    end
  end

  // Shift-JIS check; 0xA0 and above count as single bytes
  always_comb begin
    kanji_trail_d = kanji_trail_q;
    kanji_bad_d   = kanji_bad_q;
    if (!kanji_bad_q) begin
      if (kanji_trail_q) begin
        kanji_trail_d = 1'b0;
        if (!((c >= SJIS_TRAIL_LO) && (c <= SJIS_TRAIL_HI) && (c != SJIS_TRAIL_GAP))) begin
          kanji_bad_d = 1'b1;
        end
      end else if ((c < SJIS_HIGH_BIT) || (c >= SJIS_SINGLE_HI)) begin
        kanji_trail_d = 1'b0;
      end else if ((c >= SJIS_LEAD_LO) && (c <= SJIS_LEAD_HI)) begin
        kanji_trail_d = 1'b1;
      end else begin
        kanji_bad_d = 1'b1;
      end
    end
  end

  // Verdict handed to the queue at the end of a message
  assign summary_valid_o      = accept_i & (last_i | empty_message_i);
  assign summary_o.empty_msg  = empty_message_i;
  assign summary_o.numeric_ok = numeric_ok_d;
  assign summary_o.alnum_ok   = alnum_ok_d;
  assign summary_o.utf8_ok    = !utf8_bad_d && (utf8_pending_d == 2'd0);
  assign summary_o.kanji_ok   = !kanji_bad_d && !kanji_trail_d;

  // Check state; cleared at every message end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      numeric_ok_q   <= 1'b1;
      alnum_ok_q     <= 1'b1;
      utf8_pending_q <= 2'd0;
      utf8_bad_q     <= 1'b0;
      kanji_trail_q  <= 1'b0;
      kanji_bad_q    <= 1'b0;
    end else if (accept_i) begin
      if (last_i || empty_message_i) begin
        numeric_ok_q   <= 1'b1;
        alnum_ok_q     <= 1'b1;
        utf8_pending_q <= 2'd0;
        utf8_bad_q     <= 1'b0;
        kanji_trail_q  <= 1'b0;
        kanji_bad_q    <= 1'b0;
      end else begin
        numeric_ok_q   <= numeric_ok_d;
        alnum_ok_q     <= alnum_ok_d;
        utf8_pending_q <= utf8_pending_d;
        utf8_bad_q     <= utf8_bad_d;
        kanji_trail_q  <= kanji_trail_d;
        kanji_bad_q    <= kanji_bad_d;
      end
    end
  end

  // A message end leaves every check in its cleared state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    summary_valid_o |=> (numeric_ok_q && alnum_ok_q && !utf8_bad_q &&
                         (utf8_pending_q == 2'd0) && !kanji_trail_q && !kanji_bad_q))
    else $error("checks not cleared after message end");

  // A failed UTF-8 check owes no continuation bytes beyond what it held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (utf8_bad_q && accept_i && !last_i && !empty_message_i) |=>
      (utf8_bad_q && $stable(utf8_pending_q)))
    else $error("UTF-8 failure not sticky");

endmodule

`default_nettype wire

/* rtl/qrmc_queue.sv */
// Short queue of message verdicts between the classifier and the result stage.
`default_nettype none

module qrmc_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              wr_en_i,
  input  wire qrmc_pkg::summary_t wr_data_i,
  output logic                   full_o,
  input  wire logic              rd_en_i,
  output qrmc_pkg::summary_t     rd_data_o,
  output logic                   empty_o
);
  import qrmc_pkg::*;

  summary_t                entry_q [QueueDepth];
  logic [QueuePtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0]    count_q, count_d;

  assign full_o    = (count_q == QueueCntW'(QueueDepth));
  assign empty_o   = (count_q == '0);
  assign rd_data_o = entry_q[rd_ptr_q];

  // Occupancy
  always_comb begin
    count_d = count_q;
    if (wr_en_i && !rd_en_i) begin
      count_d = count_q + QueueCntW'(1);
    end else if (!wr_en_i && rd_en_i) begin
      count_d = count_q - QueueCntW'(1);
    end
  end

  // Pointers and occupancy register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (wr_en_i) begin
        wr_ptr_q <= (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + QueuePtrW'(1);
      end
      if (rd_en_i) begin
        rd_ptr_q <= (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + QueuePtrW'(1);
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      entry_q[wr_ptr_q] <= wr_data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_en_i && full_o))
    else $error("queue write while full");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QueueCntW'(QueueDepth))
    else $error("queue count overflow");

endmodule

`default_nettype wire

/* rtl/qrmc_back.sv */
// Result stage: picks the mode by priority and holds it for the consumer.
`default_nettype none

module qrmc_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire qrmc_pkg::summary_t summary_i,
  input  wire logic              summary_avail_i,
  output logic                   summary_take_o,
  output logic                   empty,
  input  wire logic              pop,
  output logic [1:0]             mode_o,
  output logic [1:0]             status_o
);
  import qrmc_pkg::*;

  logic       valid_q;
  logic [1:0] mode_q, mode_d;
  logic [1:0] status_q, status_d;

  // Priority: numeric, alphanumeric, byte, kanji
  always_comb begin
    mode_d   = MODE_NUMERIC;
    status_d = STATUS_OK;
    if (summary_i.empty_msg) begin
      status_d = STATUS_EMPTY;
    end else if (summary_i.numeric_ok) begin
      mode_d = MODE_NUMERIC;
    end else if (summary_i.alnum_ok) begin
      mode_d = MODE_ALNUM;
    end else if (summary_i.utf8_ok) begin
      mode_d = MODE_BYTE;
    end else if (summary_i.kanji_ok) begin
      mode_d = MODE_KANJI;
    end else begin
      status_d = STATUS_NO_MODE;
    end
  end

  // Load when the output register is free or being drained
  assign summary_take_o = summary_avail_i && (!valid_q || pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (summary_take_o) begin
      valid_q <= 1'b1;
    end else if (pop) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (summary_take_o) begin
      mode_q   <= mode_d;
      status_q <= status_d;
    end
  end

  assign empty    = !valid_q;
  assign mode_o   = mode_q;
  assign status_o = status_q;

  // A waiting verdict reaches an idle output register in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (summary_avail_i && !valid_q) |=> valid_q)
    else $error("verdict not loaded into idle output");

  // Mode is numeric whenever status reports a problem
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && (status_q != STATUS_OK)) |-> (mode_q == MODE_NUMERIC))
    else $error("mode nonzero with error status");

endmodule

`default_nettype wire

/* rtl/qr_encoding_mode_classifier_top.sv */
// Top level of the QR data-mode classifier.
`default_nettype none

// Takes a message one byte per request and reports one result per message:
// the first QR data mode that fits (numeric, alphanumeric, byte as UTF-8,
// kanji as Shift-JIS), or status "empty" / "no supported mode". One byte is
// accepted every cycle while full is low; the per-byte checks are
// combinational compares. The verdict for a message is written to the queue
// when its last byte is accepted and moves into the output register once that
// register is free or being popped. A two-entry verdict queue sits between the
// classifier and the output register, so full rises only when two finished
// verdicts wait behind an unpopped result.

module qr_encoding_mode_classifier_top (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       last_i,
  input  wire logic       empty_message_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [1:0]      mode_o,
  output logic [1:0]      status_o
);
  import qrmc_pkg::*;

  logic     accept;
  summary_t front_summary;
  logic     front_valid;
  summary_t queue_summary;
  logic     queue_empty;
  logic     queue_take;

  assign accept = push && !full;

  qrmc_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .data_byte_i     (data_byte_i),
    .last_i          (last_i),
    .empty_message_i (empty_message_i),
    .summary_o       (front_summary),
    .summary_valid_o (front_valid)
  );

  qrmc_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (front_valid),
    .wr_data_i (front_summary),
    .full_o    (full),
    .rd_en_i   (queue_take),
    .rd_data_o (queue_summary),
    .empty_o   (queue_empty)
  );

  qrmc_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .summary_i       (queue_summary),
    .summary_avail_i (!queue_empty),
    .summary_take_o  (queue_take),
    .empty           (empty),
    .pop             (pop),
    .mode_o          (mode_o),
    .status_o        (status_o)
  );

endmodule

`default_nettype wire
